>>> rtl/core/pdb_pkg.sv
`timescale 1ns / 1ps

package pdb_pkg;

  // Coordinate width, 1/4096 m units, two's complement
  localparam int CoordBits = 16;
  localparam int ColorBits = 24;
  // Distance, length and offset registers
  localparam int DistBits  = 12;

  localparam logic [DistBits-1:0]  LenMax   = 12'd2048;
  localparam logic [ColorBits-1:0] DimGreen = 24'h000300;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DASHES_ENABLED = 2'd0,
    CFG_ON_LENGTH      = 2'd1,
    CFG_OFF_LENGTH     = 2'd2,
    CFG_START_OFFSET   = 2'd3
  } pdb_cfg_idx_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] pos_x;
    logic signed [CoordBits-1:0] pos_y;
    logic [ColorBits-1:0]        color_in;
    logic                        line_start;
  } pdb_in_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] out_x;
    logic signed [CoordBits-1:0] out_y;
    logic [ColorBits-1:0]        color_out;
    logic                        blanked;
  } pdb_out_t;

endpackage

>>> rtl/core/polyline_dash_blanker.sv
`timescale 1ns / 1ps

// Dash pattern blanker for laser polylines.
// Input channel in_valid / in_stall / in_data carries one point per transfer;
// output channel out_valid / out_stall / out_data returns the same point,
// recolored dim green when it falls in a dark gap of the dash pattern.
// The config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
// dashes_enabled, on_length, off_length and start_offset; cfg_ready is
// always high. Write it only while no point is in flight.
// A point's result is registered on the edge that takes the point.
// After a point the running distance is updated serially. A line start
// with a nonzero period reduces the 12-bit start offset modulo the period.
// An active dashed point runs bit-serial squaring of the deltas, then a
// radix-4 square root with the root reduced modulo the period bit by bit,
// while the old distance is reduced alongside, and then folds in the old
// distance. Other points need no serial work.
// The next point is taken once that work ends and the output register is
// free or being emptied; a stalled output therefore holds off the input.
// Reset (synchronous, rst_n low) clears the distance and the previous
// point, empties the output and loads the register reset values.
module polyline_dash_blanker
  import pdb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pdb_in_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pdb_out_t            out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [DistBits-1:0] cfg_data
);

  localparam int SqW     = 2 * CoordBits + 2;  // dx^2 + dy^2, padded to pairs
  localparam int RootW   = CoordBits + 1;
  localparam int RemW    = CoordBits + 2;
  localparam int TrialW  = RemW + 2;
  localparam int CntW    = $clog2(CoordBits + 2);
  localparam int AuxCntW = $clog2(DistBits + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_OFFSET = 5'b00010,
    ST_SQUARE = 5'b00100,
    ST_ROOT   = 5'b01000,
    ST_ACCUM  = 5'b10000
  } pdb_state_t;

  // One restoring step of a serial modulo: shift in one bit, subtract once
  function automatic logic [DistBits-1:0] mod_step(input logic [DistBits-1:0] r,
                                                   input logic b,
                                                   input logic [DistBits:0] p);
    logic [DistBits:0] t;
    begin
      t = {r, b};
      if (t >= p) t = t - p;
      return t[DistBits-1:0];
    end
  endfunction

  pdb_state_t             state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  pdb_out_t               out_data_r, out_data_nxt;
  logic                   en_r, en_nxt;
  logic [DistBits-1:0]    on_r, on_nxt, off_r, off_nxt, ofs_r, ofs_nxt;
  logic [DistBits-1:0]    pd_r, pd_nxt;
  logic [CoordBits-1:0]   prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [CoordBits-1:0]   dx_r, dx_nxt, dy_r, dy_nxt, dxs_r, dxs_nxt, dys_r, dys_nxt;
  logic [SqW-1:0]         sq_r, sq_nxt;
  logic [RemW-1:0]        rem_r, rem_nxt;
  logic [RootW-1:0]       root_r, root_nxt;
  logic [DistBits-1:0]    mod_r, mod_nxt;
  logic [CntW-1:0]        cnt_r, cnt_nxt;
  logic [DistBits-1:0]    aux_sh_r, aux_sh_nxt, aux_r, aux_nxt;
  logic [AuxCntW-1:0]     aux_cnt_r, aux_cnt_nxt;

  logic [DistBits-1:0]    on_sat, off_sat;
  logic [DistBits:0]      period;
  logic                   active, out_free, accept, blank;
  logic [CoordBits:0]     dx_raw, dy_raw;
  logic [CoordBits-1:0]   dx_mag, dy_mag;
  logic [SqW-1:0]         sq_add;
  logic [TrialW-1:0]      trial, trial_sub, trial_dif;
  logic                   root_bit;
  logic [DistBits:0]      accum;

  // Saturated lengths and the dash period
  assign on_sat  = (on_r > LenMax) ? LenMax : on_r;
  assign off_sat = (off_r > LenMax) ? LenMax : off_r;
  assign period  = {1'b0, on_sat} + {1'b0, off_sat};
  assign active  = en_r && (period != '0);

  // Handshakes
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && out_free);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Segment deltas, magnitudes
  assign dx_raw = {in_data.pos_x[CoordBits-1], in_data.pos_x}
                - {prev_x_r[CoordBits-1], prev_x_r};
  assign dy_raw = {in_data.pos_y[CoordBits-1], in_data.pos_y}
                - {prev_y_r[CoordBits-1], prev_y_r};
  assign dx_mag = dx_raw[CoordBits] ? CoordBits'(-dx_raw) : dx_raw[CoordBits-1:0];
  assign dy_mag = dy_raw[CoordBits] ? CoordBits'(-dy_raw) : dy_raw[CoordBits-1:0];

  assign blank = !in_data.line_start && active && (pd_r < off_sat);

  // Bit-serial squaring, MSB first: acc = 2*acc + bit*dx + bit*dy
  assign sq_add = (sq_r << 1)
                + (dxs_r[CoordBits-1] ? SqW'(dx_r) : '0)
                + (dys_r[CoordBits-1] ? SqW'(dy_r) : '0);

  // Radix-4 restoring square root step
  assign trial     = {rem_r, sq_r[SqW-1 -: 2]};
  assign trial_sub = {1'b0, root_r, 2'b01};
  assign root_bit  = (trial >= trial_sub);
  assign trial_dif = trial - trial_sub;

  // Old distance (reduced) plus root (reduced), one correction
  assign accum = {1'b0, aux_r} + {1'b0, mod_r};

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    en_nxt        = en_r;
    on_nxt        = on_r;
    off_nxt       = off_r;
    ofs_nxt       = ofs_r;
    pd_nxt        = pd_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    dxs_nxt       = dxs_r;
    dys_nxt       = dys_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    mod_nxt       = mod_r;
    cnt_nxt       = cnt_r;
    aux_sh_nxt    = aux_sh_r;
    aux_nxt       = aux_r;
    aux_cnt_nxt   = aux_cnt_r;

    // Configuration writes
    if (cfg_valid && cfg_ready) begin
      unique case (pdb_cfg_idx_t'(cfg_index))
        CFG_DASHES_ENABLED: en_nxt  = cfg_data[0];
        CFG_ON_LENGTH:      on_nxt  = cfg_data;
        CFG_OFF_LENGTH:     off_nxt = cfg_data;
        CFG_START_OFFSET:   ofs_nxt = cfg_data;
        default:            en_nxt  = en_r;
      endcase
    end

    // Output register
    if (accept) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.out_x     = in_data.pos_x;
      out_data_nxt.out_y     = in_data.pos_y;
      out_data_nxt.color_out = blank ? DimGreen : in_data.color_in;
      out_data_nxt.blanked   = blank;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // Auxiliary serial reducer: start offset or old distance modulo period
    if (aux_cnt_r != '0) begin
      aux_nxt     = mod_step(aux_r, aux_sh_r[DistBits-1], period);
      aux_sh_nxt  = aux_sh_r << 1;
      aux_cnt_nxt = aux_cnt_r - 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          prev_x_nxt = in_data.pos_x;
          prev_y_nxt = in_data.pos_y;
          if (in_data.line_start) begin
            if (period == '0) begin
              pd_nxt = '0;
            end else begin
              aux_sh_nxt  = ofs_r;
              aux_nxt     = '0;
              aux_cnt_nxt = AuxCntW'(DistBits);
              state_nxt   = ST_OFFSET;
            end
          end else if (active) begin
            dx_nxt      = dx_mag;
            dy_nxt      = dy_mag;
            dxs_nxt     = dx_mag;
            dys_nxt     = dy_mag;
            sq_nxt      = '0;
            cnt_nxt     = CntW'(CoordBits);
            aux_sh_nxt  = pd_r;
            aux_nxt     = '0;
            aux_cnt_nxt = AuxCntW'(DistBits);
            state_nxt   = ST_SQUARE;
          end
        end
      end
      ST_OFFSET: begin
        if (aux_cnt_r == '0) begin
          pd_nxt    = aux_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_SQUARE: begin
        sq_nxt  = sq_add;
        dxs_nxt = dxs_r << 1;
        dys_nxt = dys_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          mod_nxt   = '0;
          cnt_nxt   = CntW'(RootW);
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        rem_nxt  = root_bit ? trial_dif[RemW-1:0] : trial[RemW-1:0];
        root_nxt = {root_r[RootW-2:0], root_bit};
        mod_nxt  = mod_step(mod_r, root_bit, period);
        sq_nxt   = sq_r << 2;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) state_nxt = ST_ACCUM;
      end
      ST_ACCUM: begin
        pd_nxt    = (accum >= period) ? DistBits'(accum - period) : accum[DistBits-1:0];
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      en_r        <= 1'b0;
      on_r        <= '0;
      off_r       <= 12'd1024;
      ofs_r       <= '0;
      pd_r        <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      cnt_r       <= '0;
      aux_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      en_r        <= en_nxt;
      on_r        <= on_nxt;
      off_r       <= off_nxt;
      ofs_r       <= ofs_nxt;
      pd_r        <= pd_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      cnt_r       <= cnt_nxt;
      aux_cnt_r   <= aux_cnt_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    dxs_r      <= dxs_nxt;
    dys_r      <= dys_nxt;
    sq_r       <= sq_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    mod_r      <= mod_nxt;
    aux_sh_r   <= aux_sh_nxt;
    aux_r      <= aux_nxt;
  end

  // Checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (state_r == ST_IDLE))
    else $error("point taken while busy");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid_r)
    else $error("taken point left no result");

  a_aux_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACCUM) |-> (aux_cnt_r == '0))
    else $error("distance reduction not finished at accumulate");

  a_pd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACCUM) |=> (pd_r < period))
    else $error("distance left outside the period");

endmodule
